FILE: rtl/mjpd_pkg.sv
`default_nettype none
package mjpd_pkg;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_NO_LEN   = 2'd2;
  localparam logic [1:0] ERR_TOO_BIG  = 2'd3;

  localparam logic [1:0] DP_IDLE   = 2'd0;
  localparam logic [1:0] DP_SKIP   = 2'd1;
  localparam logic [1:0] DP_DIGITS = 2'd2;
  localparam logic [1:0] DP_DONE   = 2'd3;

  localparam logic PH_HEADER  = 1'b0;
  localparam logic PH_PAYLOAD = 1'b1;

  localparam logic CFG_MAX_FRAME = 1'b0;
  localparam logic CFG_PADDING   = 1'b1;

  localparam logic [3:0]  LABEL_LEN   = 4'd15;
  localparam logic [7:0]  LABEL_FIRST = 8'h43;
  localparam logic [31:0] END_MARK    = 32'h0D0A0D0A;
  localparam logic [7:0]  JPEG_MARK   = 8'hFF;
  localparam logic [7:0]  JPEG_EOI    = 8'hD9;
  localparam logic [7:0]  CHAR_ZERO   = 8'h30;
  localparam logic [7:0]  CHAR_NINE   = 8'h39;

  localparam logic [30:0] MAX_FRAME_RESET = 31'd16777216;
  localparam logic [7:0]  PADDING_RESET   = 8'd64;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] err;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } step_out_t;

  // "Content-Length:"
  function automatic logic [7:0] label_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h4C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic res_t mk_res(input logic [1:0] kind, input logic [7:0] data,
                                  input logic last, input logic [1:0] err);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.last = last;
    r.err  = err;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mjpd_step.sv
`default_nettype none
module mjpd_step
  import mjpd_pkg::*;
#(
  parameter int HEADER_MAX  = 512,
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic [30:0] max_frame_i,
  input  wire logic [7:0]  padding_i,
  output step_out_t        out_o
);

  localparam int HC_W = $clog2(HEADER_MAX + 1);
  localparam int ML   = LENGTH_BITS + 4;
  localparam int CW   = ((LENGTH_BITS > 31) ? LENGTH_BITS : 31) + 1;

  logic                   phase_q, phase_d;
  logic [HC_W-1:0]        hdr_cnt_q, hdr_cnt_d;
  logic [31:0]            recent_q, recent_d;
  logic [3:0]             lbl_prog_q, lbl_prog_d;
  logic                   lbl_found_q, lbl_found_d;
  logic [1:0]             dig_ph_q, dig_ph_d;
  logic                   zero_q, zero_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic [7:0]             held_q, held_d;
  logic                   held_vld_q, held_vld_d;

  logic [HC_W-1:0] cnt_inc;
  logic [31:0]     recent_n;
  logic            zero_n;
  logic            is_digit;
  logic [ML-1:0]   prod;
  logic [3:0]      prog_n;
  logic            end_hit;
  logic            too_big;
  logic            clr_hdr;
  step_out_t       res;

  assign cnt_inc  = hdr_cnt_q + HC_W'(1);
  assign recent_n = {recent_q[23:0], byte_i};
  assign zero_n   = zero_q | (byte_i == 8'h00);
  assign is_digit = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign prod     = (ML'(len_q) << 3) + (ML'(len_q) << 1) + ML'(byte_i[3:0]);
  assign end_hit  = !zero_n && (cnt_inc >= HC_W'(5)) && (recent_n == END_MARK);
  assign too_big  = (CW'(len_q) + CW'(padding_i)) > CW'(max_frame_i);

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    recent_d    = recent_q;
    lbl_prog_d  = lbl_prog_q;
    lbl_found_d = lbl_found_q;
    dig_ph_d    = dig_ph_q;
    zero_d      = zero_q;
    len_d       = len_q;
    left_d      = left_q;
    held_d      = held_q;
    held_vld_d  = held_vld_q;
    clr_hdr     = 1'b0;
    prog_n      = 4'd0;
    res         = '0;

    if (phase_q == PH_PAYLOAD) begin
      if (left_q > LENGTH_BITS'(1)) begin
        left_d = left_q - LENGTH_BITS'(1);
        if (held_vld_q) begin
          res.cnt = 2'd1;
          res.r0  = mk_res(KIND_DATA, held_q, 1'b0, ERR_NONE);
        end
        held_d     = byte_i;
        held_vld_d = 1'b1;
      end else begin
        if (!held_vld_q) begin
          res.cnt = 2'd1;
          res.r0  = mk_res(KIND_DATA, byte_i, 1'b1, ERR_NONE);
        end else if (len_q > LENGTH_BITS'(2) &&
                     !(held_q == JPEG_MARK && byte_i == JPEG_EOI)) begin
          res.cnt = 2'd1;
          res.r0  = mk_res(KIND_DATA, held_q, 1'b1, ERR_NONE);
        end else begin
          res.cnt = 2'd2;
          res.r0  = mk_res(KIND_DATA, held_q, 1'b0, ERR_NONE);
          res.r1  = mk_res(KIND_DATA, byte_i, 1'b1, ERR_NONE);
        end
        phase_d    = PH_HEADER;
        left_d     = '0;
        held_vld_d = 1'b0;
        held_d     = '0;
        len_d      = '0;
        clr_hdr    = 1'b1;
      end
    end else begin
      hdr_cnt_d = cnt_inc;
      recent_d  = recent_n;
      zero_d    = zero_n;
      if (!zero_n) begin
        if (dig_ph_q == DP_SKIP) begin
          dig_ph_d = DP_DIGITS;
        end else if (dig_ph_q == DP_DIGITS) begin
          if (is_digit) begin
            if (prod > ML'({LENGTH_BITS{1'b1}})) begin
              len_d = {LENGTH_BITS{1'b1}};
            end else begin
              len_d = prod[LENGTH_BITS-1:0];
            end
          end else begin
            dig_ph_d = DP_DONE;
          end
        end
        if (!lbl_found_q) begin
          if (lbl_prog_q < LABEL_LEN && byte_i == label_char(lbl_prog_q)) begin
            prog_n = lbl_prog_q + 4'd1;
          end else begin
            prog_n = (byte_i == LABEL_FIRST) ? 4'd1 : 4'd0;
          end
          lbl_prog_d = prog_n;
          if (prog_n >= LABEL_LEN) begin
            lbl_found_d = 1'b1;
            dig_ph_d    = DP_SKIP;
            len_d       = '0;
          end
        end
      end else if (dig_ph_q == DP_SKIP || dig_ph_q == DP_DIGITS) begin
        dig_ph_d = DP_DONE;
      end

      if (end_hit) begin
        clr_hdr = 1'b1;
        if (!lbl_found_q) begin
          res.cnt = 2'd1;
          res.r0  = mk_res(KIND_ERROR, 8'h00, 1'b0, ERR_NO_LEN);
          len_d   = '0;
        end else if (too_big) begin
          res.cnt = 2'd1;
          res.r0  = mk_res(KIND_ERROR, 8'h00, 1'b0, ERR_TOO_BIG);
          len_d   = '0;
        end else if (len_q == '0) begin
          res.cnt = 2'd1;
          res.r0  = mk_res(KIND_EMPTY, 8'h00, 1'b1, ERR_NONE);
        end else begin
          phase_d    = PH_PAYLOAD;
          left_d     = len_q;
          held_vld_d = 1'b0;
          held_d     = '0;
        end
      end else if (cnt_inc >= HC_W'(HEADER_MAX)) begin
        clr_hdr = 1'b1;
        res.cnt = 2'd1;
        res.r0  = mk_res(KIND_ERROR, 8'h00, 1'b0, ERR_OVERFLOW);
        len_d   = '0;
      end
    end

    if (clr_hdr) begin
      hdr_cnt_d   = '0;
      recent_d    = '0;
      lbl_prog_d  = '0;
      lbl_found_d = 1'b0;
      dig_ph_d    = DP_IDLE;
      zero_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= '0;
      recent_q    <= '0;
      lbl_prog_q  <= '0;
      lbl_found_q <= 1'b0;
      dig_ph_q    <= DP_IDLE;
      zero_q      <= 1'b0;
      len_q       <= '0;
      left_q      <= '0;
      held_q      <= '0;
      held_vld_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      recent_q    <= recent_d;
      lbl_prog_q  <= lbl_prog_d;
      lbl_found_q <= lbl_found_d;
      dig_ph_q    <= dig_ph_d;
      zero_q      <= zero_d;
      len_q       <= len_d;
      left_q      <= left_d;
      held_q      <= held_d;
      held_vld_q  <= held_vld_d;
    end
  end

  always_comb begin
    out_o = res;
    if (!fire_i) begin
      out_o.cnt = 2'd0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mjpd_resq.sv
`default_nettype none
module mjpd_resq
  import mjpd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire step_out_t push_i,
  input  wire logic      pop_i,
  output res_t           head_o,
  output logic           valid_o,
  output logic           room_o
);

  localparam int DEPTH = 4;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  res_t             ent_q [DEPTH];
  res_t             ent_d [DEPTH];
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] base1;

  assign head_o  = ent_q[0];
  assign valid_o = (cnt_q != '0);
  // two free slots needed for a worst-case beat
  assign room_o  = (cnt_q <= CNT_W'(DEPTH - 2));

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_d[i] = ent_q[i];
    end
    base = cnt_q;
    if (pop_i) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        ent_d[i] = ent_q[i + 1];
      end
      base = cnt_q - CNT_W'(1);
    end
    base1 = base + CNT_W'(1);
    if (push_i.cnt != 2'd0) begin
      ent_d[base[IDX_W-1:0]] = push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      ent_d[base1[IDX_W-1:0]] = push_i.r1;
    end
    cnt_d = base + CNT_W'(push_i.cnt);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mjpeg_http_part_deframer.sv
// an accepted byte is held in an input register, and the result beats it causes are registered in a result queue
// throughput: one stream byte per cycle while that queue has room for two more result beats
// the final byte of a part can yield two result beats; the input stalls only while
// more than two result beats wait at the output
// reset: header scan, all counters and match state cleared, no pending results,
// max_frame_bytes = 16777216 and frame_padding = 64
`default_nettype none
module mjpeg_http_part_deframer
  import mjpd_pkg::*;
#(
  parameter int HEADER_MAX  = 512,
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  stream_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       kind_o,
  output logic [7:0]       payload_byte_o,
  output logic             frame_last_o,
  output logic [1:0]       error_code_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [30:0] cfg_data_i
);

  logic        in_vld_q;
  logic [7:0]  in_byte_q;
  logic        fire;
  logic        accept;
  logic        room;
  logic [30:0] max_frame_q;
  logic [7:0]  padding_q;
  step_out_t   step_out;
  res_t        head;

  assign fire        = in_vld_q & room;
  assign in_stall_o  = in_vld_q & ~fire;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= stream_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= MAX_FRAME_RESET;
      padding_q   <= PADDING_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MAX_FRAME: max_frame_q <= cfg_data_i;
        CFG_PADDING:   padding_q   <= cfg_data_i[7:0];
        default:       max_frame_q <= max_frame_q;
      endcase
    end
  end

  mjpd_step #(
    .HEADER_MAX  (HEADER_MAX),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte_q),
    .max_frame_i (max_frame_q),
    .padding_i   (padding_q),
    .out_o       (step_out)
  );

  mjpd_resq u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step_out),
    .pop_i   (out_valid_o & ~out_stall_i),
    .head_o  (head),
    .valid_o (out_valid_o),
    .room_o  (room)
  );

  assign kind_o         = head.kind;
  assign payload_byte_o = head.data;
  assign frame_last_o   = head.last;
  assign error_code_o   = head.err;

endmodule
`default_nettype wire

FILE: dv/mjpeg_http_part_deframer_tb.sv
`timescale 1ns / 1ps

module mjpeg_http_part_deframer_tb;
  import mjpd_pkg::*;

  localparam int          HDR_MAX   = 512;
  localparam int          HOLD_LEN  = 400;
  localparam logic [119:0] LABEL_TXT = "Content-Length:";

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  stream_byte_i = 8'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  kind_o;
  logic [7:0]  payload_byte_o;
  logic        frame_last_o;
  logic [1:0]  error_code_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_MAX_FRAME;
  logic [30:0] cfg_data_i = 31'd0;

  mjpeg_http_part_deframer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .payload_byte_o (payload_byte_o),
    .frame_last_o   (frame_last_o),
    .error_code_o   (error_code_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  res_t        beats_due[$];
  int unsigned bad_beats = 0;
  int unsigned bytes_sent = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  int unsigned hold_seq = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  // deframer state mirror
  logic [30:0] max_frame;
  logic [7:0]  pad;
  logic        ph;
  int unsigned hdr_cnt;
  logic [31:0] recent;
  int unsigned lbl_pos;
  logic        lbl_found;
  logic [1:0]  dphase;
  logic        zseen;
  logic [31:0] len_val;
  logic [31:0] left;
  logic [7:0]  held;
  logic        held_v;

  function automatic logic [7:0] label_at(input int unsigned i);
    return LABEL_TXT[8*(14-i) +: 8];
  endfunction

  task automatic expect_beat(input logic [1:0] k, input logic [7:0] d, input logic l,
                             input logic [1:0] e);
    res_t r;
    r.kind = k;
    r.data = d;
    r.last = l;
    r.err  = e;
    beats_due.push_back(r);
  endtask

  task automatic clear_scan();
    hdr_cnt   = 0;
    recent    = 32'd0;
    lbl_pos   = 0;
    lbl_found = 1'b0;
    dphase    = DP_IDLE;
    zseen     = 1'b0;
  endtask

  task automatic reject_header(input logic [1:0] code);
    expect_beat(KIND_ERROR, 8'd0, 1'b0, code);
    clear_scan();
    len_val = 32'd0;
  endtask

  task automatic reset_mirror();
    max_frame = MAX_FRAME_RESET;
    pad       = PADDING_RESET;
    ph        = PH_HEADER;
    clear_scan();
    len_val   = 32'd0;
    left      = 32'd0;
    held      = 8'd0;
    held_v    = 1'b0;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic [63:0] acc;
    logic [32:0] need;
    if (ph == PH_PAYLOAD) begin
      if (left > 32'd1) begin
        left = left - 32'd1;
        if (held_v) expect_beat(KIND_DATA, held, 1'b0, ERR_NONE);
        held   = b;
        held_v = 1'b1;
      end else begin
        if (!held_v) begin
          expect_beat(KIND_DATA, b, 1'b1, ERR_NONE);
        end else if (len_val > 32'd2 && !(held == JPEG_MARK && b == JPEG_EOI)) begin
          expect_beat(KIND_DATA, held, 1'b1, ERR_NONE);
        end else begin
          expect_beat(KIND_DATA, held, 1'b0, ERR_NONE);
          expect_beat(KIND_DATA, b, 1'b1, ERR_NONE);
        end
        ph      = PH_HEADER;
        left    = 32'd0;
        held_v  = 1'b0;
        held    = 8'd0;
        len_val = 32'd0;
        clear_scan();
      end
    end else begin
      hdr_cnt = hdr_cnt + 1;
      recent  = {recent[23:0], b};
      if (b == 8'd0) zseen = 1'b1;
      if (!zseen) begin
        if (dphase == DP_SKIP) begin
          dphase = DP_DIGITS;
        end else if (dphase == DP_DIGITS) begin
          if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            acc = {32'd0, len_val} * 64'd10 + {56'd0, b - CHAR_ZERO};
            len_val = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
          end else begin
            dphase = DP_DONE;
          end
        end
        if (!lbl_found) begin
          if (lbl_pos < LABEL_LEN && b == label_at(lbl_pos)) lbl_pos = lbl_pos + 1;
          else lbl_pos = (b == LABEL_FIRST) ? 1 : 0;
          if (lbl_pos >= LABEL_LEN) begin
            lbl_found = 1'b1;
            dphase    = DP_SKIP;
            len_val   = 32'd0;
          end
        end
      end else if (dphase == DP_SKIP || dphase == DP_DIGITS) begin
        dphase = DP_DONE;
      end
      need = {1'b0, len_val} + {25'd0, pad};
      if (!zseen && hdr_cnt >= 5 && recent == END_MARK) begin
        if (!lbl_found) begin
          reject_header(ERR_NO_LEN);
        end else if (need > {2'b00, max_frame}) begin
          reject_header(ERR_TOO_BIG);
        end else begin
          clear_scan();
          if (len_val == 32'd0) begin
            expect_beat(KIND_EMPTY, 8'd0, 1'b1, ERR_NONE);
          end else begin
            ph     = PH_PAYLOAD;
            left   = len_val;
            held_v = 1'b0;
            held   = 8'd0;
          end
        end
      end else if (hdr_cnt >= HDR_MAX) begin
        reject_header(ERR_OVERFLOW);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (hold_seen != hold_seq) begin
      hold_seen   <= hold_seq;
      hold_left   <= HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_gaps && ($urandom_range(0, 99) < 21);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (beats_due.size() == 0) begin
        $display("%0t: beat with none expected: kind %0d byte %02h last %0d err %0d",
                 $time, kind_o, payload_byte_o, frame_last_o, error_code_o);
        bad_beats++;
      end else begin
        want = beats_due.pop_front();
        if ({kind_o, payload_byte_o, frame_last_o, error_code_o} !== want) begin
          $display("%0t: expected kind/byte/last/err %0d/%02h/%0d/%0d, got %0d/%02h/%0d/%0d",
                   $time, want.kind, want.data, want.last, want.err,
                   kind_o, payload_byte_o, frame_last_o, error_code_o);
          bad_beats++;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (tx_gaps && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    stream_byte_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_len_header(input string len_txt);
    send_text({"Content-Length: ", len_txt, "\r\n\r\n"});
  endtask

  task automatic send_payload(input int unsigned len, input bit eoi_tail);
    for (int unsigned i = 0; i < len; i++) begin
      if (eoi_tail && len >= 2 && i == len - 2) send_byte(JPEG_MARK);
      else if (eoi_tail && len >= 2 && i == len - 1) send_byte(JPEG_EOI);
      else send_byte(8'($urandom));
    end
  endtask

  // fill the current header with filler until the scan restarts
  task automatic fill_to_overflow();
    do send_byte("a"); while (hdr_cnt != 0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [30:0] max_data, input logic [30:0] pad_data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_MAX_FRAME;
    cfg_data_i  <= max_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_PADDING;
    cfg_data_i  <= pad_data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    max_frame = max_data;
    pad       = pad_data[7:0];
  endtask

  task automatic test_directed_parts();
    send_len_header("0");
    send_len_header("1");
    send_byte(8'h00);
    send_len_header("2");
    send_byte(8'hFF);
    send_byte(8'h12);
    send_len_header("3");
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hD9);
    send_len_header("3");
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h7F);
    send_len_header("4");
    send_byte(8'hFF);
    send_byte(8'hD9);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_text("Content-Length:\r\n\r\n");
    send_text("x\r\n\r\n");
    send_text("\r\n\r\n\r\n");
    send_text("CContent-Length: 2\r\nContent-Length: 9\r\n\r\n");
    send_payload(2, 1'b0);
    send_len_header("99999999999");
    send_text("Content-Length:x7\r\n\r\n");
    send_payload(7, 1'b1);
    settle();
  endtask

  task automatic test_header_limits();
    // zero byte stops matching, only the size limit ends this header
    send_text("Content-Length: 3");
    send_byte(8'h00);
    send_text("\r\n\r\n");
    fill_to_overflow();
    // header end on the very last allowed byte
    send_text("Content-Length: 0\r\n");
    while (hdr_cnt < HDR_MAX - 4) send_byte("a");
    send_text("\r\n\r\n");
    settle();
  endtask

  task automatic test_size_limits();
    write_regs(31'd0, 31'h7FFF_FF00);
    send_len_header("0");
    send_len_header("1");
    settle();
    write_regs(31'd30, 31'd0);
    send_len_header("30");
    send_payload(30, 1'b1);
    send_len_header("31");
    settle();
    write_regs(31'd255, 31'd255);
    send_len_header("0");
    send_len_header("1");
    settle();
    write_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send_len_header("2147483393");
    send_len_header("4294967295");
    send_len_header("3");
    send_payload(3, 1'b0);
    settle();
    write_regs(MAX_FRAME_RESET, {23'd0, PADDING_RESET});
  endtask

  task automatic test_backpressure();
    tx_gaps = 1'b0;
    hold_seq <= hold_seq + 1;
    send_len_header("40");
    send_payload(40, 1'b1);
    repeat (4) begin
      send_len_header("5");
      send_payload(5, 1'b0);
    end
    tx_gaps = 1'b1;
    settle();
  endtask

  task automatic send_random_part();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      if ($urandom_range(0, 1)) send_text("--frame\r\n");
      if ($urandom_range(0, 1)) send_text("Content-Type: image/jpeg\r\n");
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 24);
      send_text("Content-Length:");
      send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(33, 126)) : " ");
      send_text($sformatf("%0d", len));
      if ($urandom_range(0, 3) == 0) send_text("\r\nX-Tag: 7");
      send_text("\r\n\r\n");
      if ($urandom_range(0, 9) == 0 && len > 1) len = $urandom_range(0, len - 1);
      send_payload(len, $urandom_range(0, 1));
    end else if (pick < 78) begin
      repeat ($urandom_range(1, 30)) send_byte(8'($urandom_range(1, 255)));
    end else if (pick < 86) begin
      case ($urandom_range(0, 2))
        0:       send_text("content-length: 5\r\n\r\n");
        1:       send_text("Content-Lengt: 3\r\n\r\n");
        default: send_text("Content-Len\r\n\r\n");
      endcase
    end else if (pick < 94) begin
      send_len_header($sformatf("%0d", $urandom | 32'h8000_0000));
    end else if (pick < 96) begin
      send_text("Content-Length: 4");
      send_byte(8'h00);
      send_text("\r\n\r\n");
    end else begin
      send_len_header($sformatf("%0d", $urandom_range(1, 20)));
    end
  endtask

  task automatic test_random_stream();
    int unsigned start;
    for (int r = 0; r < 4; r++) begin
      settle();
      case (r)
        0: write_regs(MAX_FRAME_RESET, {23'd0, PADDING_RESET});
        1: write_regs(31'($urandom_range(20, 60)), 31'($urandom_range(0, 10)));
        2: write_regs(31'h7FFF_FFFF, 31'd255);
        default: write_regs(31'($urandom), 31'($urandom));
      endcase
      tx_gaps = (r != 1);
      rx_gaps <= (r != 1);
      start = bytes_sent;
      while (bytes_sent - start < 50) send_random_part();
    end
    tx_gaps = 1'b1;
    rx_gaps <= 1'b1;
  endtask

  initial begin
    reset_mirror();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_parts();
    test_header_limits();
    test_size_limits();
    test_backpressure();
    test_random_stream();
    settle();
    if (bad_beats == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
